>>> rtl/core/link_response_frame_checker_core_defines.svh
// ---------------------------------------------------------------------------
// link response frame checker assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef LINK_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH
`define LINK_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge, held off during reset
`define LRFC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every rising clock edge, reset included
`define LRFC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRFC_ASSERT(name, clk, rst, prop, msg)
`define LRFC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> rtl/core/lrfc_pkg.sv
// ---------------------------------------------------------------------------
// lrfc_pkg
// shared types, status codes and fixed frame patterns of the frame checker
// ---------------------------------------------------------------------------
package lrfc_pkg;

   localparam int HEADER_BYTES_DEF = 9;
   localparam int PATTERN_IDX_W    = 4;

   localparam logic [7:0] SYNC_BYTE = 8'hA5;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_BAD_SYNC = 3'd1,
      STATUS_ERR_FRM  = 3'd2,
      STATUS_CSUM     = 3'd3,
      STATUS_ACK_MIS  = 3'd4,
      STATUS_LEN_LONG = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first_byte;
      logic       expect_ack;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] payload_length;
      logic [7:0] computed_sum;
   } rsp_type;

   // fixed error frame A5 07 00 00 00 00 00 00 07
   function automatic logic [7:0] err_pattern(input logic [PATTERN_IDX_W-1:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = SYNC_BYTE;
         4'd1:    val = 8'h07;
         4'd8:    val = 8'h07;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // fixed acknowledge frame A5 07 FF 00 00 00 00 00 06
   function automatic logic [7:0] ack_pattern(input logic [PATTERN_IDX_W-1:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = SYNC_BYTE;
         4'd1:    val = 8'h07;
         4'd2:    val = 8'hFF;
         4'd8:    val = 8'h06;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/core/link_response_frame_checker_core.sv
// ---------------------------------------------------------------------------
// link_response_frame_checker_core
// checks response frames of a byte-serial link and reports one status each
// ---------------------------------------------------------------------------
// Takes one frame byte per request and one request per clock, unless a
// result is held up at rsp. Each request is captured in an input register;
// a single compare-and-add stage then updates the frame state and, at the
// frame's last byte, loads the result register, whose status shows on rsp.
// The input register keeps accepting while a result waits; only a request
// that would produce a second result stalls until rsp is taken. Status
// priority is bad sync, error frame, then acknowledge mismatch (send mode)
// or length too long ahead of checksum mismatch (receive mode). Bytes after
// a frame's end are dropped until a request with first_byte set.
// max_payload is written over csr; the user must write it only while idle,
// as the block itself does not enforce it. It resets to 191.
// ---------------------------------------------------------------------------
`include "link_response_frame_checker_core_defines.svh"

module link_response_frame_checker_core #(
   parameter int HEADER_BYTES = lrfc_pkg::HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lrfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lrfc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import lrfc_pkg::*;

   // frame index covers header plus the largest payload
   localparam int IDX_W = $clog2(HEADER_BYTES + 256);
   localparam logic [IDX_W-1:0] LEN_IDX  = IDX_W'(HEADER_BYTES - 2);
   localparam logic [IDX_W-1:0] TAIL_IDX = IDX_W'(HEADER_BYTES - 1);
   localparam logic [IDX_W-1:0] MAX_IDX  = IDX_W'(HEADER_BYTES - 1 + 255);

   // input register
   logic       a_valid_ff, a_valid_in;
   req_type    a_req_ff, a_req_in;

   // frame state
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic             sync_good_ff, sync_good_in;
   logic             match_err_ff, match_err_in;
   logic             match_ack_ff, match_ack_in;
   logic [7:0]       pay_count_ff, pay_count_in;
   logic             ack_mode_ff, ack_mode_in;
   logic             frame_done_ff, frame_done_in;

   // result register and config
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [7:0] max_payload_ff, max_payload_in;

   // frame state as seen after a restart request
   logic [IDX_W-1:0] idx_b;
   logic [7:0]       sum_b;
   logic             sync_b, merr_b, mack_b, ackm_b, done_b;
   logic [7:0]       cnt_b;

   // per byte evaluation
   logic [7:0]       rx_b;
   logic             sync_n, merr_n, mack_n;
   logic [7:0]       cnt_n;
   logic [IDX_W-1:0] last_idx;
   logic             hit_last;
   logic             out_free;
   logic             a_fire;
   logic             res_load;
   status_type       status_n;

   always_comb begin
      rx_b = a_req_ff.rx_byte;

      // restart clears the frame and latches the mode
      if (a_req_ff.first_byte) begin
         idx_b  = '0;
         sum_b  = '0;
         sync_b = 1'b0;
         merr_b = 1'b1;
         mack_b = 1'b1;
         cnt_b  = '0;
         ackm_b = a_req_ff.expect_ack;
         done_b = 1'b0;
      end else begin
         idx_b  = byte_index_ff;
         sum_b  = running_sum_ff;
         sync_b = sync_good_ff;
         merr_b = match_err_ff;
         mack_b = match_ack_ff;
         cnt_b  = pay_count_ff;
         ackm_b = ack_mode_ff;
         done_b = frame_done_ff;
      end

      sync_n = (idx_b == '0) ? (rx_b == SYNC_BYTE) : sync_b;
      merr_n = merr_b;
      mack_n = mack_b;
      if (idx_b < IDX_W'(HEADER_BYTES)) begin
         merr_n = merr_b && (rx_b == err_pattern(idx_b[PATTERN_IDX_W-1:0]));
         mack_n = mack_b && (rx_b == ack_pattern(idx_b[PATTERN_IDX_W-1:0]));
      end
      cnt_n = (idx_b == LEN_IDX) ? rx_b : cnt_b;

      // frame end: fixed in send mode, header plus payload in receive mode
      last_idx = ackm_b ? TAIL_IDX : (TAIL_IDX + IDX_W'(cnt_n));
      hit_last = !done_b && (idx_b >= TAIL_IDX) && (idx_b == last_idx);

      if (!sync_n) begin
         status_n = STATUS_BAD_SYNC;
      end else if (merr_n) begin
         status_n = STATUS_ERR_FRM;
      end else if (ackm_b) begin
         status_n = mack_n ? STATUS_OK : STATUS_ACK_MIS;
      end else if (cnt_n > max_payload_ff) begin
         status_n = STATUS_LEN_LONG;
      end else if (rx_b != sum_b) begin
         status_n = STATUS_CSUM;
      end else begin
         status_n = STATUS_OK;
      end

      // a result needs a free output slot, anything else always proceeds
      out_free = !rsp_valid_ff || rsp_ready;
      a_fire   = a_valid_ff && (!hit_last || out_free);
      res_load = a_fire && hit_last;

      req_ready  = !a_valid_ff || a_fire;
      a_valid_in = req_ready ? req_valid : a_valid_ff;
      a_req_in   = (req_ready && req_valid) ? req_data : a_req_ff;

      // state follows the processed byte
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      sync_good_in   = sync_good_ff;
      match_err_in   = match_err_ff;
      match_ack_in   = match_ack_ff;
      pay_count_in   = pay_count_ff;
      ack_mode_in    = ack_mode_ff;
      frame_done_in  = frame_done_ff;
      if (a_fire) begin
         ack_mode_in   = ackm_b;
         frame_done_in = done_b;
         if (done_b) begin
            byte_index_in  = idx_b;
            running_sum_in = sum_b;
            sync_good_in   = sync_b;
            match_err_in   = merr_b;
            match_ack_in   = mack_b;
            pay_count_in   = cnt_b;
         end else begin
            sync_good_in = sync_n;
            match_err_in = merr_n;
            match_ack_in = mack_n;
            pay_count_in = cnt_n;
            if (hit_last) begin
               // index and sum freeze at the checksum byte
               byte_index_in  = idx_b;
               running_sum_in = sum_b;
               frame_done_in  = 1'b1;
            end else begin
               byte_index_in  = idx_b + 1'b1;
               running_sum_in = (idx_b != '0) ? (sum_b + rx_b) : sum_b;
            end
         end
      end

      // result register
      rsp_valid_in = res_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_data_in.status         = status_n;
         rsp_data_in.payload_length = ackm_b ? 8'd0 : cnt_n;
         rsp_data_in.computed_sum   = sum_b;
      end

      // config register, always ready
      csr_ready      = 1'b1;
      max_payload_in = csr_valid ? csr_data : max_payload_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byte_index_ff  <= '0;
         running_sum_ff <= '0;
         sync_good_ff   <= 1'b0;
         match_err_ff   <= 1'b1;
         match_ack_ff   <= 1'b1;
         pay_count_ff   <= '0;
         ack_mode_ff    <= 1'b0;
         frame_done_ff  <= 1'b0;
         max_payload_ff <= 8'd191;
      end else begin
         a_valid_ff     <= a_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         byte_index_ff  <= byte_index_in;
         running_sum_ff <= running_sum_in;
         sync_good_ff   <= sync_good_in;
         match_err_ff   <= match_err_in;
         match_ack_ff   <= match_ack_in;
         pay_count_ff   <= pay_count_in;
         ack_mode_ff    <= ack_mode_in;
         frame_done_ff  <= frame_done_in;
         max_payload_ff <= max_payload_in;
      end
      a_req_ff    <= a_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // index never runs past the longest possible frame
   `LRFC_ASSERT(a_idx_range, clock, reset, byte_index_ff <= MAX_IDX, "byte index out of range")
   // a loaded result closes the frame
   `LRFC_ASSERT(a_done_after_load, clock, reset, res_load |=> frame_done_ff, "frame not closed")
   // a result is never loaded over one still waiting
   `LRFC_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp_ready) |-> !res_load,
                "result overwritten")
   // reported status stays within the defined codes
   `LRFC_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_data.status <= STATUS_LEN_LONG),
                "undefined status")

endmodule

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// link_response_frame_checker_core testbench
// self-checking regression: frames are built, streamed a byte per request and
// every returned status is checked against a cycle-free frame predictor
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrfc_pkg::*;

   localparam int CLK_HIGH       = 6;
   localparam int CLK_LOW        = 6;
   localparam int RESET_CYCLES   = 7;
   localparam int HEADER_LEN     = HEADER_BYTES_DEF;
   // a status passes the input and result registers after its last byte, a stray
   // byte may still sit in the input register, so a few quiet cycles make the block idle
   localparam int DRAIN_CYCLES   = 6;
   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;

   // fixed error and acknowledge frames
   localparam logic [7:0] ERR_FRAME [9] = '{8'hA5, 8'h07, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00, 8'h07};
   localparam logic [7:0] ACK_FRAME [9] = '{8'hA5, 8'h07, 8'hFF, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00, 8'h06};

   typedef enum int {
      FK_CLEAN,
      FK_BAD_SYNC,
      FK_ERROR,
      FK_CORRUPT,
      FK_TRUNCATED,
      FK_NOISE
   } frame_kind_type;

   typedef logic [7:0] byte_q_type [$];

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [7:0] csr_data = '0;

   // frame tracking state, values after reset
   logic [8:0] frm_index    = '0;
   logic [7:0] frm_sum      = '0;
   logic       frm_sync_ok  = 1'b0;
   logic       frm_err_like = 1'b1;
   logic       frm_ack_like = 1'b1;
   logic [7:0] frm_len      = '0;
   logic       frm_ack_mode = 1'b0;
   logic       frm_closed   = 1'b0;
   logic [7:0] frm_limit    = 8'd191;

   rsp_type pending_status_q [$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int fail_count    = 0;
   int req_count     = 0;
   int rsp_count     = 0;
   int csr_writes    = 0;
   int status_seen [8];

   link_response_frame_checker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #CLK_LOW clock = 1'b1;
      #CLK_HIGH clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // frame predictor: advances on every accepted request, queues a status
   // at the frame's last byte
   // ------------------------------------------------------------------------
   task automatic predict_frame_status(input req_type r);
      logic [8:0] last_idx;
      rsp_type    res;
      // first_byte restarts the frame and latches the mode
      if (r.first_byte) begin
         frm_index    = '0;
         frm_sum      = '0;
         frm_sync_ok  = 1'b0;
         frm_err_like = 1'b1;
         frm_ack_like = 1'b1;
         frm_len      = '0;
         frm_ack_mode = r.expect_ack;
         frm_closed   = 1'b0;
      end
      // bytes past the end of a frame are dropped
      if (!frm_closed) begin
         if (frm_index == 0)
            frm_sync_ok = (r.rx_byte == SYNC_BYTE);
         if (frm_index < HEADER_LEN) begin
            if (r.rx_byte != ERR_FRAME[frm_index[3:0]])
               frm_err_like = 1'b0;
            if (r.rx_byte != ACK_FRAME[frm_index[3:0]])
               frm_ack_like = 1'b0;
         end
         if (frm_index == HEADER_LEN - 2)
            frm_len = r.rx_byte;
         // acknowledge frames are header only, receive frames carry frm_len more
         last_idx = frm_ack_mode ? 9'(HEADER_LEN - 1) : 9'(HEADER_LEN - 1) + 9'(frm_len);
         if (frm_index == last_idx) begin
            // priority: sync, error frame, then mode specific checks
            if (!frm_sync_ok)
               res.status = STATUS_BAD_SYNC;
            else if (frm_err_like)
               res.status = STATUS_ERR_FRM;
            else if (frm_ack_mode)
               res.status = frm_ack_like ? STATUS_OK : STATUS_ACK_MIS;
            else if (frm_len > frm_limit)
               res.status = STATUS_LEN_LONG;
            else if (r.rx_byte != frm_sum)
               res.status = STATUS_CSUM;
            else
               res.status = STATUS_OK;
            res.payload_length = frm_ack_mode ? 8'd0 : frm_len;
            res.computed_sum   = frm_sum;
            pending_status_q.push_back(res);
            frm_closed = 1'b1;
         end else begin
            // byte 0 is the sync byte, left out of the sum
            if (frm_index != 0)
               frm_sum = frm_sum + r.rx_byte;
            frm_index = frm_index + 9'd1;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // request side
   // valid stays high between back to back requests; it is only lowered
   // for a gap, before a pause, or before a register write
   // ------------------------------------------------------------------------
   task automatic send_req(input req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_frame_status(r);
      req_count++;
   endtask

   // stop offering and wait until every status is back and the block is idle
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_status_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      frm_limit = value;
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // builds a frame of the given kind; n is the payload count of receive frames
   function automatic byte_q_type build_frame(input frame_kind_type kind, input logic ack,
                                              input int n);
      byte_q_type f;
      logic [7:0] sum;
      logic [7:0] b;
      int         k;
      int         keep;
      sum = '0;
      if (kind == FK_ERROR) begin
         foreach (ERR_FRAME[i]) f.push_back(ERR_FRAME[i]);
      end else if (kind == FK_NOISE) begin
         repeat ($urandom_range(9, 20)) f.push_back(8'($urandom));
      end else if (ack) begin
         foreach (ACK_FRAME[i]) f.push_back(ACK_FRAME[i]);
      end else begin
         // sync, six free header bytes, length, payload, then the checksum
         f.push_back(SYNC_BYTE);
         for (k = 1; k < HEADER_LEN - 2; k++) begin
            b = 8'($urandom);
            f.push_back(b);
            sum = sum + b;
         end
         f.push_back(8'(n));
         sum = sum + 8'(n);
         repeat (n) begin
            b = 8'($urandom);
            f.push_back(b);
            sum = sum + b;
         end
         f.push_back(sum);
      end
      case (kind)
         FK_BAD_SYNC: begin
            f[0] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
         end
         FK_CORRUPT: begin
            // ack frames get one header byte flipped, receive frames a bad checksum
            if (ack) begin
               k = $urandom_range(1, HEADER_LEN - 1);
               f[k] = f[k] ^ 8'($urandom_range(1, 255));
            end else begin
               f[f.size() - 1] = f[f.size() - 1] ^ 8'($urandom_range(1, 255));
            end
         end
         FK_TRUNCATED: begin
            keep = $urandom_range(1, f.size() - 1);
            f = f[0:keep - 1];
         end
         default: ;
      endcase
      return f;
   endfunction

   // lead low leaves first_byte clear on byte 0; trail adds bytes past the end
   task automatic send_frame(input byte_q_type f, input logic ack, input logic lead,
                             input int trail);
      req_type r;
      foreach (f[i]) begin
         r.rx_byte    = f[i];
         r.first_byte = (i == 0) && lead;
         // expect_ack only counts on a first byte, so it toggles freely elsewhere
         r.expect_ack = (i == 0) ? ack : 1'($urandom);
         send_req(r);
      end
      repeat (trail) begin
         r.rx_byte    = 8'($urandom);
         r.first_byte = 1'b0;
         r.expect_ack = 1'($urandom);
         send_req(r);
      end
   endtask

   // well-formed frames two times in five, the rest broken, cut short or noise
   task automatic random_frames(input int budget);
      int             sent;
      int             pick;
      int             n;
      int             trail;
      logic           ack;
      frame_kind_type kind;
      byte_q_type     f;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 40)
            kind = FK_CLEAN;
         else if (pick < 50)
            kind = FK_BAD_SYNC;
         else if (pick < 60)
            kind = FK_ERROR;
         else if (pick < 80)
            kind = FK_CORRUPT;
         else if (pick < 90)
            kind = FK_TRUNCATED;
         else
            kind = FK_NOISE;
         ack   = ($urandom_range(99) < 40);
         // short payloads mostly, now and then a medium one
         n     = ($urandom_range(99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
         trail = (kind != FK_TRUNCATED && $urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
         f     = build_frame(kind, ack, n);
         send_frame(f, ack, 1'b1, trail);
         sent += f.size();
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // byte 0 straight after reset without first_byte, then a clean ack frame,
   // a dropped byte past its end and a receive frame with all-ones free header bytes
   task automatic test_after_reset();
      byte_q_type f;
      int         k;
      f = build_frame(FK_ERROR, 1'b0, 0);
      send_frame(f, 1'b1, 1'b0, 0);
      f = build_frame(FK_CLEAN, 1'b1, 0);
      send_frame(f, 1'b1, 1'b1, 1);
      f = build_frame(FK_CLEAN, 1'b0, 0);
      for (k = 1; k < HEADER_LEN - 2; k++) f[k] = 8'hFF;
      f[HEADER_LEN - 1] = 8'hFA;
      send_frame(f, 1'b0, 1'b1, 0);
   endtask

   // register extremes, full rate on both sides
   task automatic test_length_limits();
      write_limit(8'd0);
      random_frames(60);
      write_limit(8'd1);
      random_frames(60);
      write_limit(8'd255);
      random_frames(60);
   endtask

   task automatic test_sender_gaps();
      write_limit(8'($urandom_range(2, 254)));
      req_idle_pct  = 64;
      rsp_stall_pct <= 0;
      random_frames(150);
   endtask

   task automatic test_receiver_stalls();
      write_limit(8'd191);
      req_idle_pct  = 0;
      rsp_stall_pct <= 64;
      random_frames(150);
   endtask

   task automatic test_mixed_idling();
      write_limit(8'($urandom_range(2, 254)));
      req_idle_pct  = 13;
      rsp_stall_pct <= 13;
      random_frames(150);
   endtask

   // receiver holds off while requests keep coming, so the block fills and
   // stalls its input; afterwards the sender waits for every status
   task automatic test_backpressure();
      write_limit(8'd8);
      req_idle_pct  = 0;
      rsp_stall_pct <= 0;
      hold_token    <= hold_token + 1;
      random_frames(60);
      wait_drain();
   endtask

   // one frame with the largest payload count
   task automatic test_longest_frame();
      byte_q_type f;
      write_limit(8'd255);
      req_idle_pct  = 13;
      rsp_stall_pct <= 13;
      f = build_frame(FK_CLEAN, 1'b0, 255);
      send_frame(f, 1'b0, 1'b1, 1);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_length_limits();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_backpressure();
      test_longest_frame();
      wait_drain();
      $display("covered %0d requests, %0d statuses, %0d max_payload writes",
               req_count, rsp_count, csr_writes);
      $display("statuses ok %0d, bad sync %0d, error frame %0d, checksum %0d, ack %0d, long %0d",
               status_seen[STATUS_OK], status_seen[STATUS_BAD_SYNC],
               status_seen[STATUS_ERR_FRM], status_seen[STATUS_CSUM],
               status_seen[STATUS_ACK_MIS], status_seen[STATUS_LEN_LONG]);
      if (fail_count == 0 && pending_status_q.size() == 0) begin
         $display("link_response_frame_checker_core regression: pass");
      end else begin
         $display("link_response_frame_checker_core regression: fail");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: random stalls, plus a long hold-off when asked for
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // status check against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (rsp_data.status <= STATUS_LEN_LONG)
            status_seen[rsp_data.status]++;
         if (pending_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected status: status %0d length %0d sum %02h",
                        rsp_data.status, rsp_data.payload_length, rsp_data.computed_sum);
         end else begin
            want = pending_status_q.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.payload_length !== want.payload_length
                || rsp_data.computed_sum !== want.computed_sum) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("status mismatch: want %0d/%0d/%02h got %0d/%0d/%02h",
                           want.status, want.payload_length, want.computed_sum,
                           rsp_data.status, rsp_data.payload_length, rsp_data.computed_sum);
            end
         end
      end
   end

   // watchdog: too many cycles without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d statuses outstanding",
                  quiet_cycles, pending_status_q.size());
         $display("link_response_frame_checker_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
